// ----- rtl/core/sync_byte_deframer_with_value_queue_top_assert.svh -----
// Assertion macros for the sync byte deframer core.
// Used by modules that have aclk and aresetn in scope; NO_ASSERTIONS removes them.
`ifndef SYNC_BYTE_DEFRAMER_WITH_VALUE_QUEUE_TOP_ASSERT_SVH
`define SYNC_BYTE_DEFRAMER_WITH_VALUE_QUEUE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked at every edge out of reset
`define SBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent at one edge, consequent at the next
`define SBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SBD_ASSERT(lbl, prop, msg)
`define SBD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/sbd_pkg.sv -----
// Shared types and constants for the sync byte deframer core.
// No dependencies.
package sbd_pkg;

    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = 8;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int NUM_VALUES  = 4;
    localparam int VALUE_W     = 16;
    localparam int ENTRY_W     = NUM_VALUES * VALUE_W;

    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hA5;

    // Meaning of the input tuser bit
    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    // Frame receiver state
    typedef enum logic {
        FR_HUNT    = 1'b0,
        FR_COLLECT = 1'b1
    } fr_state_t;

    // Completed frame handed to the queue
    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] entry;
    } push_t;

endpackage

// ----- rtl/core/sbd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sbd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/sbd_framer.sv -----
// Sync hunt and payload collection; builds one 64-bit value set per frame.
// Depends on sbd_pkg.
module sbd_framer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [sbd_pkg::BYTE_W-1:0] cfg_wdata,
    input  logic                      byte_vld,
    input  logic [sbd_pkg::BYTE_W-1:0] byte_in,
    output sbd_pkg::push_t            push
);

    sbd_pkg::fr_state_t             state_reg, state_next;
    logic [sbd_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [sbd_pkg::BYTE_W-1:0]     sync_reg;
    logic [sbd_pkg::BYTE_W-1:0]     shift_reg [sbd_pkg::FRAME_BYTES-1];
    logic [sbd_pkg::BYTE_W-1:0]     frame [sbd_pkg::FRAME_BYTES];
    logic                           last_byte;

    // Sync byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= sbd_pkg::SYNC_RESET;
        end else if (cfg_we) begin
            sync_reg <= cfg_wdata;
        end
    end

    // State and byte counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbd_pkg::FR_HUNT;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload shift line, newest byte in slot 0
    always_ff @(posedge aclk) begin
        if (byte_vld && state_reg == sbd_pkg::FR_COLLECT) begin
            shift_reg[0] <= byte_in;
            for (int i = 1; i < sbd_pkg::FRAME_BYTES - 1; i++) begin
                shift_reg[i] <= shift_reg[i-1];
            end
        end
    end

    assign last_byte = (cnt_reg == sbd_pkg::CNT_W'(sbd_pkg::FRAME_BYTES - 1));

    // Frame bytes in arrival order; the last one comes straight from the input
    always_comb begin
        for (int j = 0; j < sbd_pkg::FRAME_BYTES - 1; j++) begin
            frame[j] = shift_reg[sbd_pkg::FRAME_BYTES - 2 - j];
        end
        frame[sbd_pkg::FRAME_BYTES-1] = byte_in;
    end

    // Value set, next state and push strobe
    always_comb begin
        // Pair bytes high first into values; value k lands in bits 16k+15..16k
        for (int k = 0; k < sbd_pkg::NUM_VALUES; k++) begin
            push.entry[k*sbd_pkg::VALUE_W +: sbd_pkg::VALUE_W] = {frame[2*k], frame[2*k+1]};
        end
        state_next = state_reg;
        cnt_next   = cnt_reg;
        push.valid = 1'b0;
        if (byte_vld) begin
            unique case (state_reg)
                sbd_pkg::FR_HUNT: begin
                    cnt_next = '0;
                    if (byte_in == sync_reg) begin
                        state_next = sbd_pkg::FR_COLLECT;
                    end
                end
                sbd_pkg::FR_COLLECT: begin
                    if (last_byte) begin
                        push.valid = 1'b1;
                        cnt_next   = '0;
                        state_next = sbd_pkg::FR_HUNT;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default: begin
                    state_next = sbd_pkg::FR_HUNT;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/sbd_queue.sv -----
// Ring queue of value sets with overwrite-oldest push, plus read and output stages.
// Depends on sbd_pkg, sbd_ram and the assertion macro header.
`include "sync_byte_deframer_with_value_queue_top_assert.svh"

module sbd_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sbd_pkg::push_t              push,
    input  logic                        pop_req,
    output logic                        ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sbd_pkg::ENTRY_W-1:0] m_tdata
);

    logic [sbd_pkg::QPTR_W-1:0]  wr_reg, wr_next;
    logic [sbd_pkg::QPTR_W-1:0]  rd_reg, rd_next;
    logic [sbd_pkg::QFILL_W-1:0] fill_reg, fill_next;
    logic                        full, empty, do_pop;
    logic                        p_vld_reg, p_vld_next, p_zero_reg, p_adv;
    logic                        m_vld_reg, m_vld_next;
    logic [sbd_pkg::ENTRY_W-1:0] m_data_reg, m_data_next;
    logic [sbd_pkg::ENTRY_W-1:0] rdata;

    function automatic logic [sbd_pkg::QPTR_W-1:0] next_slot(
        input logic [sbd_pkg::QPTR_W-1:0] p
    );
        if (p == sbd_pkg::QPTR_W'(sbd_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full   = (fill_reg == sbd_pkg::QFILL_W'(sbd_pkg::QUEUE_DEPTH));
    assign empty  = (fill_reg == '0);
    assign do_pop = pop_req && !empty;

    // Pointer and fill update; push and pop never coincide
    always_comb begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push.valid) begin
            wr_next = next_slot(wr_reg);
            if (full) begin
                rd_next = next_slot(rd_reg);
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end else if (do_pop) begin
            rd_next   = next_slot(rd_reg);
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    sbd_ram #(
        .WIDTH (sbd_pkg::ENTRY_W),
        .DEPTH (sbd_pkg::QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (push.valid),
        .waddr (wr_reg),
        .wdata (push.entry),
        .re    (do_pop),
        .raddr (rd_reg),
        .rdata (rdata)
    );

    // Read stage waits on RAM data; output register holds the result
    assign p_adv = !m_vld_reg || m_tready;
    assign ready = !p_vld_reg || p_adv;

    always_comb begin
        p_vld_next  = p_vld_reg;
        m_vld_next  = m_vld_reg;
        m_data_next = m_data_reg;
        if (p_vld_reg && p_adv) begin
            m_vld_next  = 1'b1;
            m_data_next = p_zero_reg ? '0 : rdata;
            p_vld_next  = 1'b0;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
        if (pop_req) begin
            p_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else begin
            p_vld_reg <= p_vld_next;
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_req) begin
            p_zero_reg <= empty;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    `SBD_ASSERT(a_fill_bound, fill_reg <= sbd_pkg::QFILL_W'(sbd_pkg::QUEUE_DEPTH), "fill over depth")
    `SBD_ASSERT_NEXT(a_pop_dec, aresetn && do_pop, fill_reg == $past(fill_reg) - 1'b1, "pop not counted")
    `SBD_ASSERT_NEXT(a_full_push, aresetn && push.valid && full, full && rd_reg != $past(rd_reg), "full push lost oldest")
    `SBD_ASSERT_NEXT(a_empty_zero, aresetn && p_vld_reg && p_zero_reg && p_adv, m_tvalid && m_tdata == '0, "empty read not zero")

endmodule

// ----- rtl/core/sync_byte_deframer_with_value_queue_top.sv -----
// Top level of the sync byte deframer with value queue.
// Depends on sbd_pkg, sbd_framer and sbd_queue.
//
// Channel   Ports                    Content
// input     s_tvalid/s_tready        s_tuser: kind; s_tdata: rx_byte
// result    m_tvalid/m_tready        m_tdata: speed_0..speed_3, speed_0 lowest
// config    cfg_we/cfg_wdata         sync_byte
//
// One item per cycle in either kind while s_tready is high. A read result passes through
// the registered RAM read and then the output register before it leaves on m_tdata.
// Reset (aresetn low, synchronous) clears the hunt state, pointers and fill level;
// the value store needs no clearing pass. s_tready drops only while a read result
// waits in the output register and another waits on the RAM read stage.
module sync_byte_deframer_with_value_queue_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [sbd_pkg::BYTE_W-1:0]   cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sbd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic                         s_tuser,   // [0] kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sbd_pkg::ENTRY_W-1:0]  m_tdata    // speed_0 .. speed_3, 16 bits each
);

    logic           s_xfer;
    logic           byte_vld;
    logic           pop_req;
    sbd_pkg::push_t push;

    // Split accepted transactions by kind
    assign s_xfer   = s_tvalid && s_tready;
    assign byte_vld = s_xfer && (s_tuser == sbd_pkg::KIND_BYTE);
    assign pop_req  = s_xfer && (s_tuser == sbd_pkg::KIND_READ);

    sbd_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .byte_vld  (byte_vld),
        .byte_in   (s_tdata),
        .push      (push)
    );

    sbd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop_req  (pop_req),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- tb/sync_byte_deframer_with_value_queue_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the sync byte deframer: follows the hunt/collect state and the value-set
// queue, predicts every read result and compares it with the result channel.
// Depends on sbd_pkg.
module sync_byte_deframer_with_value_queue_checker
    import sbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [BYTE_W-1:0]  cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic               s_tuser,   // [0] kind
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [ENTRY_W-1:0] m_tdata,   // speed_0 .. speed_3, speed_0 lowest
    output int                 mismatches,
    output int                 pending
);

    localparam int MAX_REPORTS = 10;

    // Shadow copy of the receiver and queue
    logic [BYTE_W-1:0]  sync_val;
    fr_state_t          rx_state;
    logic [CNT_W-1:0]   frame_pos;
    logic [BYTE_W-1:0]  frame_buf [FRAME_BYTES];
    logic [ENTRY_W-1:0] set_store [QUEUE_DEPTH];
    int                 wr_slot;
    int                 rd_slot;
    int                 sets_held;

    // Speed sets owed on the result channel, oldest first
    logic [ENTRY_W-1:0] speeds_due [$];

    // One received byte: hunt for sync, then gather eight payload bytes
    function automatic void take_rx_byte(logic [BYTE_W-1:0] b);
        logic [ENTRY_W-1:0] speeds;
        if (rx_state == FR_HUNT) begin
            if (b == sync_val)
                rx_state = FR_COLLECT;
            return;
        end
        frame_buf[frame_pos] = b;
        if (frame_pos != CNT_W'(FRAME_BYTES - 1)) begin
            frame_pos++;
            return;
        end
        // high byte first within each value
        for (int k = 0; k < NUM_VALUES; k++)
            speeds[k*VALUE_W +: VALUE_W] = {frame_buf[2*k], frame_buf[2*k+1]};
        set_store[wr_slot] = speeds;
        wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
        // full queue: oldest set is overwritten
        if (sets_held == QUEUE_DEPTH)
            rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
        else
            sets_held++;
        frame_pos = '0;
        rx_state  = FR_HUNT;
    endfunction

    // Read request: oldest set, or all zeros from an empty queue
    function automatic logic [ENTRY_W-1:0] pop_speed_set();
        logic [ENTRY_W-1:0] speeds;
        speeds = '0;
        if (sets_held != 0) begin
            speeds  = set_store[rd_slot];
            rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
            sets_held--;
        end
        return speeds;
    endfunction

    always @(posedge aclk) begin : watch
        logic [ENTRY_W-1:0] want;
        if (!aresetn) begin
            sync_val  = SYNC_RESET;
            rx_state  = FR_HUNT;
            frame_pos = '0;
            wr_slot   = 0;
            rd_slot   = 0;
            sets_held = 0;
            speeds_due.delete();
        end else begin
            if (cfg_we)
                sync_val = cfg_wdata;

            // result transaction against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (speeds_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] unexpected result, m_tdata=%h", $time, m_tdata);
                end else begin
                    want = speeds_due.pop_front();
                    for (int k = 0; k < NUM_VALUES; k++) begin
                        if (m_tdata[k*VALUE_W +: VALUE_W] !== want[k*VALUE_W +: VALUE_W]) begin
                            mismatches++;
                            if (mismatches <= MAX_REPORTS)
                                $display("[%0t] speed_%0d: expected %0d, got %0d", $time, k,
                                         $signed(want[k*VALUE_W +: VALUE_W]),
                                         $signed(m_tdata[k*VALUE_W +: VALUE_W]));
                        end
                    end
                end
            end

            // input transaction
            if (s_tvalid && s_tready) begin
                if (kind_t'(s_tuser) == KIND_READ)
                    speeds_due.push_back(pop_speed_set());
                else
                    take_rx_byte(s_tdata);
            end
        end
        pending <= speeds_due.size();
    end

endmodule

// ----- tb/sync_byte_deframer_with_value_queue_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the sync byte deframer: clock, reset, byte/read stimulus, result sink
// and verdict. Depends on sbd_pkg, the DUT and sync_byte_deframer_with_value_queue_checker.
module sync_byte_deframer_with_value_queue_top_tb;
    import sbd_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [BYTE_W-1:0]  cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic               s_tuser   = 1'b0; // [0] kind
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [ENTRY_W-1:0] m_tdata;          // speed_0 .. speed_3, speed_0 lowest

    int                 mismatches;
    int                 pending;
    int                 hold_reqs   = 0;
    int                 holds_done  = 0;
    int                 idle_cycles = 0;
    bit                 tx_steady   = 1'b0;
    logic [BYTE_W-1:0]  cur_sync    = SYNC_RESET;

    sync_byte_deframer_with_value_queue_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sync_byte_deframer_with_value_queue_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result sink: random gaps, steady stretches, one long hold-off on request
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_reqs != holds_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end
            gap = ((taken / 40) % 3 == 2) ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // One input transaction, after a random gap unless the sender runs steady
    task automatic send_item(kind_t kind, logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending until every read result is back and the pipe has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sync(logic [BYTE_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cur_sync   = v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Payload byte biased toward the extremes of a 16-bit value and the sync value
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            4: return cur_sync;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mix of whole frames with random content, read requests and noise bytes
    task automatic run_phase(int n, int read_pct, int noise_pct);
        int sent;
        int pick;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < read_pct) begin
                send_item(KIND_READ, 8'($urandom));
                sent++;
            end else if (pick < read_pct + noise_pct) begin
                send_item(KIND_BYTE, 8'($urandom));
                sent++;
            end else begin
                send_item(KIND_BYTE, cur_sync);
                sent++;
                for (int j = 0; j < FRAME_BYTES; j++) begin
                    if ($urandom_range(0, 99) < read_pct / 2) begin
                        send_item(KIND_READ, 8'($urandom));
                        sent++;
                    end
                    send_item(KIND_BYTE, pick_byte());
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // read from the empty queue, noise while hunting
        send_item(KIND_READ, 8'h00);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        // frame: most negative, most positive, -1, sync value taken as payload
        send_item(KIND_BYTE, SYNC_RESET);
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h7F);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, SYNC_RESET);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_READ, 8'hFF);
        send_item(KIND_READ, 8'h00);

        // sync change while a frame is partly collected
        send_item(KIND_BYTE, SYNC_RESET);
        send_item(KIND_BYTE, 8'h12);
        send_item(KIND_BYTE, 8'h34);
        send_item(KIND_BYTE, 8'h56);
        write_sync(8'h00);

        // read-heavy phase while the sink holds off: input side must stall
        hold_reqs++;
        run_phase(120, 40, 10);

        // many frames, no reads: queue wraps and overwrites, then drain past empty
        write_sync(8'hFF);
        run_phase(360, 0, 3);
        run_phase(40, 100, 0);

        // back-to-back input with heavy noise
        write_sync(8'($urandom));
        tx_steady = 1'b1;
        run_phase(150, 30, 25);
        tx_steady = 1'b0;

        write_sync(SYNC_RESET);
        run_phase(200, 15, 5);

        settle();
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sbd_pkg.sv
rtl/core/sbd_ram.sv
rtl/core/sbd_framer.sv
rtl/core/sbd_queue.sv
rtl/core/sync_byte_deframer_with_value_queue_top.sv
tb/sync_byte_deframer_with_value_queue_checker.sv
tb/sync_byte_deframer_with_value_queue_top_tb.sv
